/* src/eight_bit_cpu_alu_with_flags_top_assert.svh */
// ----------------------------------------------------------------------------
// ALU assertion macros
// Shared assertion forms for the ALU checker.
// ----------------------------------------------------------------------------
`ifndef EIGHT_BIT_CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define EIGHT_BIT_CPU_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// Property that is ignored while reset is high.
`define EBALU_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property that is checked during reset as well.
`define EBALU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/ebalu_pkg.sv */
// ----------------------------------------------------------------------------
// ALU package
// Operation codes, shift codes, flag positions and the item structs.
// ----------------------------------------------------------------------------
package ebalu_pkg;

   // Operation codes.
   typedef enum logic [4:0] {
      OP_ADD    = 5'd0,
      OP_ADC    = 5'd1,
      OP_SUB    = 5'd2,
      OP_SBC    = 5'd3,
      OP_AND    = 5'd4,
      OP_XOR    = 5'd5,
      OP_OR     = 5'd6,
      OP_CP     = 5'd7,
      OP_INC    = 5'd8,
      OP_DEC    = 5'd9,
      OP_DAA    = 5'd10,
      OP_CPL    = 5'd11,
      OP_SCF    = 5'd12,
      OP_CCF    = 5'd13,
      OP_RLC    = 5'd14,
      OP_RRC    = 5'd15,
      OP_RL     = 5'd16,
      OP_RR     = 5'd17,
      OP_SLA    = 5'd18,
      OP_SRA    = 5'd19,
      OP_SWAP   = 5'd20,
      OP_SRL    = 5'd21,
      OP_RLCA   = 5'd22,
      OP_RRCA   = 5'd23,
      OP_RLA    = 5'd24,
      OP_RRA    = 5'd25,
      OP_BIT    = 5'd26,
      OP_RES    = 5'd27,
      OP_SET    = 5'd28,
      OP_ADD16  = 5'd29,
      OP_ADD_SP = 5'd30
   } op_type;

   // Shift and rotate kinds, in the order of the CB group.
   typedef enum logic [2:0] {
      SH_RLC  = 3'd0,
      SH_RRC  = 3'd1,
      SH_RL   = 3'd2,
      SH_RR   = 3'd3,
      SH_SLA  = 3'd4,
      SH_SRA  = 3'd5,
      SH_SWAP = 3'd6,
      SH_SRL  = 3'd7
   } shift_type;

   // Flag bit positions.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // DAA constants.
   localparam logic [7:0] DAA_LOW_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HIGH_ADJ = 8'h60;
   localparam logic [7:0] DAA_LIMIT    = 8'h99;
   localparam logic [3:0] DIGIT_MAX    = 4'd9;

   // One request item.
   typedef struct packed {
      logic [4:0]  operation;
      logic [15:0] operand_a;
      logic [15:0] operand_b;
      logic [2:0]  bit_index;
      logic [3:0]  flags_in;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
      logic        write_result;
   } rsp_type;

endpackage

/* src/ebalu_req_stage.sv */
// ----------------------------------------------------------------------------
// ALU request stage
// Input register holding one request item between transfers.
// ----------------------------------------------------------------------------
module ebalu_req_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ebalu_pkg::req_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ebalu_pkg::req_type out_data
);
   import ebalu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   // The stage takes a new item when empty or when its item moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload is captured on each transfer into the stage.
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/ebalu_core.sv */
// ----------------------------------------------------------------------------
// ALU core
// Combinational datapath computing result, flags and write enable.
// ----------------------------------------------------------------------------
module ebalu_core (
   input  ebalu_pkg::req_type req,
   output ebalu_pkg::rsp_type rsp
);
   import ebalu_pkg::*;

   // Shift and rotate unit: returns carry out above the 8-bit result.
   function automatic logic [8:0] shift_op(input shift_type sel, input logic [7:0] v,
                                           input logic cin);
      logic [8:0] r;
      case (sel)
         SH_RLC:  r = {v[7], v[6:0], v[7]};
         SH_RRC:  r = {v[0], v[0], v[7:1]};
         SH_RL:   r = {v[7], v[6:0], cin};
         SH_RR:   r = {v[0], cin, v[7:1]};
         SH_SLA:  r = {v[7], v[6:0], 1'b0};
         SH_SRA:  r = {v[0], v[7], v[7:1]};
         SH_SWAP: r = {1'b0, v[3:0], v[7:4]};
         default: r = {v[0], 1'b0, v[7:1]};
      endcase
      return r;
   endfunction

   op_type      op;
   logic [7:0]  a;
   logic [7:0]  b;
   logic        zf;
   logic        nf;
   logic        hf;
   logic        cf;
   logic [15:0] res;
   logic        wr;
   logic [8:0]  t9;
   logic [7:0]  r8;
   logic [7:0]  adj;
   logic [7:0]  mask;
   logic [8:0]  sh;
   logic [4:0]  sh_off;
   logic [16:0] s17;
   logic [12:0] s13;
   logic [8:0]  s9;
   logic [4:0]  s5;

   always_comb begin
      op     = op_type'(req.operation);
      a      = req.operand_a[7:0];
      b      = req.operand_b[7:0];
      zf     = req.flags_in[FLAG_Z];
      nf     = req.flags_in[FLAG_N];
      hf     = req.flags_in[FLAG_H];
      cf     = req.flags_in[FLAG_C];
      res    = req.operand_a;
      wr     = 1'b1;
      t9     = 9'd0;
      r8     = 8'd0;
      adj    = 8'd0;
      mask   = 8'd1 << req.bit_index;
      // Both shift groups index the same unit: op - RLC, low three bits.
      sh_off = req.operation - OP_RLC;
      sh     = shift_op(shift_type'(sh_off[2:0]), a, cf);
      s17    = {1'b0, req.operand_a} + {1'b0, req.operand_b};
      s13    = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};
      s9     = {1'b0, req.operand_a[7:0]} + {1'b0, b};
      s5     = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

      unique case (op) inside
         // Eight accumulator operations with a 9-bit carry or borrow.
         OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_AND, OP_XOR, OP_OR, OP_CP: begin
            case (op) inside
               OP_ADD, OP_ADC: begin
                  t9 = {1'b0, a} + {1'b0, b} + {8'd0, (op == OP_ADC) & cf};
                  nf = 1'b0;
                  hf = t9[4] ^ a[4] ^ b[4];
               end
               OP_SUB, OP_SBC, OP_CP: begin
                  t9 = {1'b0, a} - {1'b0, b} - {8'd0, (op == OP_SBC) & cf};
                  nf = 1'b1;
                  hf = t9[4] ^ a[4] ^ b[4];
               end
               OP_AND: begin
                  t9 = {1'b0, a & b};
                  nf = 1'b0;
                  hf = 1'b1;
               end
               OP_XOR: begin
                  t9 = {1'b0, a ^ b};
                  nf = 1'b0;
                  hf = 1'b0;
               end
               default: begin
                  t9 = {1'b0, a | b};
                  nf = 1'b0;
                  hf = 1'b0;
               end
            endcase
            res = {8'h00, t9[7:0]};
            cf  = t9[8];
            zf  = (t9[7:0] == 8'h00);
            wr  = (op != OP_CP);
         end
         // Increment and decrement leave carry alone.
         OP_INC, OP_DEC: begin
            r8  = (op == OP_INC) ? a + 8'd1 : a - 8'd1;
            res = {8'h00, r8};
            hf  = r8[4] ^ a[4];
            nf  = (op == OP_DEC);
            zf  = (r8 == 8'h00);
         end
         // Decimal adjust after add or subtract.
         OP_DAA: begin
            if (hf || (!nf && (a[3:0] > DIGIT_MAX))) begin
               adj = adj | DAA_LOW_ADJ;
            end
            if (cf || (!nf && (a > DAA_LIMIT))) begin
               adj = adj | DAA_HIGH_ADJ;
               cf  = 1'b1;
            end
            r8  = nf ? a - adj : a + adj;
            res = {8'h00, r8};
            zf  = (r8 == 8'h00);
            hf  = 1'b0;
         end
         OP_CPL: begin
            res = {8'h00, ~a};
            nf  = 1'b1;
            hf  = 1'b1;
         end
         OP_SCF, OP_CCF: begin
            res = {8'h00, a};
            cf  = (op == OP_SCF) ? 1'b1 : !cf;
            nf  = 1'b0;
            hf  = 1'b0;
         end
         // CB shifts set Z from the result; accumulator rotates clear it.
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            res = {8'h00, sh[7:0]};
            cf  = sh[8];
            zf  = (op <= OP_SRL) ? (sh[7:0] == 8'h00) : 1'b0;
            nf  = 1'b0;
            hf  = 1'b0;
         end
         OP_BIT: begin
            res = {8'h00, a};
            zf  = ((a & mask) == 8'h00);
            nf  = 1'b0;
            hf  = 1'b1;
            wr  = 1'b0;
         end
         OP_RES: begin
            res = {8'h00, a & ~mask};
         end
         OP_SET: begin
            res = {8'h00, a | mask};
         end
         // HL plus a 16-bit register; Z passes through.
         OP_ADD16: begin
            res = s17[15:0];
            hf  = s13[12];
            cf  = s17[16];
            nf  = 1'b0;
         end
         // SP plus a signed byte; flags from the low-byte carries.
         OP_ADD_SP: begin
            res = req.operand_a + {{8{b[7]}}, b};
            hf  = s5[4];
            cf  = s9[8];
            zf  = 1'b0;
            nf  = 1'b0;
         end
         // Unused code: operand passes through, nothing written.
         default: begin
            res = req.operand_a;
            wr  = 1'b0;
         end
      endcase

      rsp.result       = res;
      rsp.flags_out    = {zf, nf, hf, cf};
      rsp.write_result = wr;
   end

endmodule

/* src/ebalu_rsp_stage.sv */
// ----------------------------------------------------------------------------
// ALU result stage
// Output register holding one result item until its transfer.
// ----------------------------------------------------------------------------
module ebalu_rsp_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  ebalu_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output ebalu_pkg::rsp_type out_data
);
   import ebalu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // A waiting result is replaced only when it is taken in the same cycle.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

/* src/eight_bit_cpu_alu_with_flags_top.sv */
// Path: a transferred request is held in the request register, then its result
// in the result register; both wait while the result register is still held.
// Throughput: one item per cycle unless rsp_ready stalls the result; the
// single pass through the ALU core between the two registers sets that figure.
// Reset clears both valid bits; payload registers are not reset.
// ----------------------------------------------------------------------------
// 8-bit CPU ALU with flags
// Request register, combinational ALU core and result register.
// ----------------------------------------------------------------------------
module eight_bit_cpu_alu_with_flags_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_operation,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   input  logic [2:0]  req_bit_index,
   input  logic [3:0]  req_flags_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_result,
   output logic [3:0]  rsp_flags_out,
   output logic        rsp_write_result
);
   import ebalu_pkg::*;

   req_type req_data;
   req_type stage_req;
   rsp_type core_rsp;
   rsp_type out_rsp;
   logic    stage_valid;
   logic    stage_ready;

   // Gather the request fields into one item.
   assign req_data.operation = req_operation;
   assign req_data.operand_a = req_operand_a;
   assign req_data.operand_b = req_operand_b;
   assign req_data.bit_index = req_bit_index;
   assign req_data.flags_in  = req_flags_in;

   ebalu_req_stage u_req_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (stage_valid),
      .out_ready (stage_ready),
      .out_data  (stage_req)
   );

   ebalu_core u_core (
      .req (stage_req),
      .rsp (core_rsp)
   );

   ebalu_rsp_stage u_rsp_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid),
      .in_ready  (stage_ready),
      .in_data   (core_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_rsp)
   );

   assign rsp_result       = out_rsp.result;
   assign rsp_flags_out    = out_rsp.flags_out;
   assign rsp_write_result = out_rsp.write_result;

endmodule

/* src/ebalu_checker.sv */
// ----------------------------------------------------------------------------
// ALU checker
// Port-level assertions on the ALU handshake and pipeline timing.
// ----------------------------------------------------------------------------
`include "eight_bit_cpu_alu_with_flags_top_assert.svh"

module ebalu_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_result,
   input logic [3:0]  rsp_flags_out,
   input logic        rsp_write_result
);

   // A stalled result keeps its valid and payload.
   `EBALU_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result) && $stable(rsp_flags_out) && $stable(rsp_write_result), "stalled result changed")

   // Reset empties the result register.
   `EBALU_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result valid after reset")

   // Requests are only refused while a result waits on a stalled consumer.
   `EBALU_ASSERT(a_ready_backpressure, clock, reset, !req_ready |-> rsp_valid && !rsp_ready, "request refused without backpressure")

   // An accepted request shows up as a valid result if the consumer is ready while it sits in the request register.
   `EBALU_ASSERT(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid, "result missing after two cycles")

endmodule

bind eight_bit_cpu_alu_with_flags_top ebalu_checker u_ebalu_checker (.*);

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// ALU with flags testbench
// Drives operations through the request channel and checks every result,
// field by field, against an in-order queue filled from typed-in results
// and a behavioral ALU predictor. A directed stimulus table comes first,
// then random items under several flow-control phases, one of which
// stalls the result side long enough to back up the request side.
// ----------------------------------------------------------------------------
module tb;
   import ebalu_pkg::*;

   // Operation code with no defined function; it must pass operand_a through.
   localparam logic [4:0] OP_UNUSED   = 5'd31;
   localparam int         HOLD_CYCLES = 64;
   localparam int         STUCK_LIMIT = 2000;
   localparam int         TAIL_CYCLES = 8;
   localparam int         MAX_REPORTS = 10;

   typedef enum int {
      PH_STEADY,
      PH_SEND_GAPS,
      PH_RECV_STALLS,
      PH_BOTH,
      PH_PRESSURE
   } phase_type;

   // One row of the directed stimulus; known rows carry a typed-in result.
   typedef struct {
      req_type stim;
      bit      known;
      rsp_type want;
   } stim_row_type;

   // One outstanding result, kept with its request for reporting.
   typedef struct {
      req_type stim;
      rsp_type want;
   } pending_alu_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [4:0]  req_operation;
   logic [15:0] req_operand_a;
   logic [15:0] req_operand_b;
   logic [2:0]  req_bit_index;
   logic [3:0]  req_flags_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [15:0] rsp_result;
   logic [3:0]  rsp_flags_out;
   logic        rsp_write_result;

   pending_alu_type pending_alu_results[$];
   stim_row_type    rows[$];
   phase_type       phase = PH_STEADY;
   int              send_gap_pct  = 0;
   int              rsp_stall_pct = 0;
   bit              hold_done     = 1'b0;
   int              error_count   = 0;
   int              sent_count    = 0;
   int              rcvd_count    = 0;
   int              random_issued = 0;
   int              stuck_cycles  = 0;
   bit              op_seen[32];

   eight_bit_cpu_alu_with_flags_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_operand_a    (req_operand_a),
      .req_operand_b    (req_operand_b),
      .req_bit_index    (req_bit_index),
      .req_flags_in     (req_flags_in),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result       (rsp_result),
      .rsp_flags_out    (rsp_flags_out),
      .rsp_write_result (rsp_write_result)
   );

   always #1 clock = ~clock;

   // Behavioral ALU: computes the value, flags and write enable of one item.
   function automatic rsp_type alu_predict(input req_type rq);
      logic [7:0]  acc, opb, res8, adj;
      logic [8:0]  sum9;
      logic [12:0] sum13;
      logic [4:0]  sum5;
      logic [16:0] sum17;
      logic [4:0]  shift_sel;
      logic        fz, fn, fh, fc, cin, carry_in;
      shift_type   kind;
      rsp_type     rs;
      acc = rq.operand_a[7:0];
      opb = rq.operand_b[7:0];
      {fz, fn, fh, fc} = rq.flags_in;
      cin = fc;
      rs.result = rq.operand_a;
      rs.write_result = 1'b1;
      case (rq.operation)
         OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP: begin
            carry_in = (rq.operation == OP_ADC || rq.operation == OP_SBC) ? cin : 1'b0;
            fn = !(rq.operation == OP_ADD || rq.operation == OP_ADC);
            // Bit 8 of the 9-bit sum is the carry, or the borrow when subtracting.
            if (fn) begin
               sum9 = {1'b0, acc} - {1'b0, opb} - {8'h00, carry_in};
            end else begin
               sum9 = {1'b0, acc} + {1'b0, opb} + {8'h00, carry_in};
            end
            res8 = sum9[7:0];
            fh = sum9[4] ^ acc[4] ^ opb[4];
            fc = sum9[8];
            fz = (res8 == 8'h00);
            rs.result = {8'h00, res8};
            if (rq.operation == OP_CP) rs.write_result = 1'b0;
         end
         OP_AND, OP_XOR, OP_OR: begin
            if (rq.operation == OP_AND) res8 = acc & opb;
            else if (rq.operation == OP_XOR) res8 = acc ^ opb;
            else res8 = acc | opb;
            fz = (res8 == 8'h00);
            fn = 1'b0;
            fh = (rq.operation == OP_AND);
            fc = 1'b0;
            rs.result = {8'h00, res8};
         end
         OP_INC, OP_DEC: begin
            res8 = (rq.operation == OP_INC) ? acc + 8'd1 : acc - 8'd1;
            fh = res8[4] ^ acc[4];
            fn = (rq.operation == OP_DEC);
            fz = (res8 == 8'h00);
            rs.result = {8'h00, res8};
         end
         OP_DAA: begin
            // Decimal adjust follows the direction recorded in N.
            adj = 8'h00;
            if (fh || (!fn && acc[3:0] > DIGIT_MAX)) adj = adj | DAA_LOW_ADJ;
            if (fc || (!fn && acc > DAA_LIMIT)) begin
               adj = adj | DAA_HIGH_ADJ;
               fc = 1'b1;
            end
            res8 = fn ? acc - adj : acc + adj;
            fz = (res8 == 8'h00);
            fh = 1'b0;
            rs.result = {8'h00, res8};
         end
         OP_CPL: begin
            rs.result = {8'h00, ~acc};
            fn = 1'b1;
            fh = 1'b1;
         end
         OP_SCF, OP_CCF: begin
            rs.result = {8'h00, acc};
            fc = (rq.operation == OP_SCF) ? 1'b1 : ~fc;
            fn = 1'b0;
            fh = 1'b0;
         end
         OP_RLC, OP_RRC, OP_RL, OP_RR, OP_SLA, OP_SRA, OP_SWAP, OP_SRL,
         OP_RLCA, OP_RRCA, OP_RLA, OP_RRA: begin
            shift_sel = (rq.operation <= OP_SRL) ? rq.operation - OP_RLC
                                                 : rq.operation - OP_RLCA;
            kind = shift_type'(shift_sel[2:0]);
            case (kind)
               SH_RLC:  begin res8 = {acc[6:0], acc[7]}; fc = acc[7]; end
               SH_RRC:  begin res8 = {acc[0], acc[7:1]}; fc = acc[0]; end
               SH_RL:   begin res8 = {acc[6:0], cin};    fc = acc[7]; end
               SH_RR:   begin res8 = {cin, acc[7:1]};    fc = acc[0]; end
               SH_SLA:  begin res8 = {acc[6:0], 1'b0};   fc = acc[7]; end
               SH_SRA:  begin res8 = {acc[7], acc[7:1]}; fc = acc[0]; end
               SH_SWAP: begin res8 = {acc[3:0], acc[7:4]}; fc = 1'b0; end
               default: begin res8 = {1'b0, acc[7:1]};   fc = acc[0]; end
            endcase
            // The accumulator forms always clear Z.
            fz = (rq.operation <= OP_SRL) ? (res8 == 8'h00) : 1'b0;
            fn = 1'b0;
            fh = 1'b0;
            rs.result = {8'h00, res8};
         end
         OP_BIT: begin
            rs.result = {8'h00, acc};
            fz = ~acc[rq.bit_index];
            fn = 1'b0;
            fh = 1'b1;
            rs.write_result = 1'b0;
         end
         OP_RES: rs.result = {8'h00, acc & ~(8'h01 << rq.bit_index)};
         OP_SET: rs.result = {8'h00, acc | (8'h01 << rq.bit_index)};
         OP_ADD16: begin
            sum17 = {1'b0, rq.operand_a} + {1'b0, rq.operand_b};
            sum13 = {1'b0, rq.operand_a[11:0]} + {1'b0, rq.operand_b[11:0]};
            rs.result = sum17[15:0];
            fn = 1'b0;
            fh = sum13[12];
            fc = sum17[16];
         end
         OP_ADD_SP: begin
            // Carries come from the unsigned low byte, the sum from the signed one.
            rs.result = rq.operand_a + {{8{opb[7]}}, opb};
            sum5 = {1'b0, rq.operand_a[3:0]} + {1'b0, opb[3:0]};
            sum9 = {1'b0, rq.operand_a[7:0]} + {1'b0, opb};
            fz = 1'b0;
            fn = 1'b0;
            fh = sum5[4];
            fc = sum9[8];
         end
         default: rs.write_result = 1'b0;
      endcase
      rs.flags_out = {fz, fn, fh, fc};
      return rs;
   endfunction

   function automatic stim_row_type row(input logic [4:0] op, input logic [15:0] a,
                                        input logic [15:0] b, input logic [2:0] bi,
                                        input logic [3:0] fl, input bit known,
                                        input logic [15:0] res, input logic [3:0] fo,
                                        input bit wr);
      stim_row_type r;
      r.stim  = '{operation: op, operand_a: a, operand_b: b, bit_index: bi, flags_in: fl};
      r.known = known;
      r.want  = '{result: res, flags_out: fo, write_result: wr};
      return r;
   endfunction

   function automatic logic [15:0] pick_operand();
      // Mostly random words, with a share of carry and digit boundaries.
      if ($urandom_range(3) != 0) return 16'($urandom_range(65535));
      case ($urandom_range(7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         2:       return 16'h00FF;
         3:       return 16'h0099;
         4:       return 16'h009A;
         5:       return 16'h0F0F;
         6:       return 16'h8080;
         default: return 16'h0FFF;
      endcase
   endfunction

   task automatic record_error(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("ERROR: %s", what);
   endtask

   // Offer one request, hold it until the transfer, then queue its result.
   task automatic offer(input req_type item, input rsp_type want);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= item.operation;
      req_operand_a <= item.operand_a;
      req_operand_b <= item.operand_b;
      req_bit_index <= item.bit_index;
      req_flags_in  <= item.flags_in;
      @(posedge clock);
      while (req_ready !== 1'b1) @(posedge clock);
      pending_alu_results.push_back('{stim: item, want: want});
      op_seen[item.operation] = 1'b1;
      sent_count++;
   endtask

   // Random requests; the first ones sweep every operation code in order.
   task automatic run_random(input int count);
      req_type item;
      for (int i = 0; i < count; i++) begin
         if (random_issued < 32) item.operation = random_issued[4:0];
         else if ($urandom_range(49) == 0) item.operation = OP_UNUSED;
         else item.operation = 5'($urandom_range(OP_ADD_SP));
         item.operand_a = pick_operand();
         item.operand_b = pick_operand();
         item.bit_index = 3'($urandom_range(7));
         item.flags_in  = 4'($urandom_range(15));
         random_issued++;
         offer(item, alu_predict(item));
      end
   endtask

   // Result side: random stalls, plus one long hold-off in the pressure phase.
   initial begin
      int k;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (phase == PH_PRESSURE && !hold_done) begin
            rsp_ready <= 1'b0;
            for (k = 1; k < HOLD_CYCLES; k++) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Compare each result transfer with the oldest outstanding expectation.
   always @(posedge clock) begin : check_results
      pending_alu_type e;
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         rcvd_count++;
         if (pending_alu_results.size() == 0) begin
            record_error($sformatf("unexpected result %h flags %h write %b",
                                   rsp_result, rsp_flags_out, rsp_write_result));
         end else begin
            e = pending_alu_results.pop_front();
            if (rsp_result !== e.want.result || rsp_flags_out !== e.want.flags_out ||
                rsp_write_result !== e.want.write_result) begin
               record_error($sformatf(
                  "op %0d a %h b %h bit %0d f %h: want %h/%h/%b got %h/%h/%b",
                  e.stim.operation, e.stim.operand_a, e.stim.operand_b,
                  e.stim.bit_index, e.stim.flags_in, e.want.result,
                  e.want.flags_out, e.want.write_result, rsp_result,
                  rsp_flags_out, rsp_write_result));
            end
         end
      end
   end

   // Watchdog: ends the run when no transfer happens for too long.
   always @(posedge clock) begin
      if (reset === 1'b1 || (req_valid === 1'b1 && req_ready === 1'b1) ||
          (rsp_valid === 1'b1 && rsp_ready === 1'b1)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                  STUCK_LIMIT, pending_alu_results.size());
         $display("** eight_bit_cpu_alu_with_flags_top: FAILED **");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // Main sequence: reset, directed table, then the flow-control phases.
   initial begin
      int ops_hit;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_operation = OP_ADD;
      req_operand_a = 16'h0000;
      req_operand_b = 16'h0000;
      req_bit_index = 3'd0;
      req_flags_in  = 4'h0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Extremes of each operation group and the pass-through special cases.
      rows.push_back(row(OP_ADD,    16'h00FF, 16'h0001, 3'd0, 4'h0, 1, 16'h0000, 4'hB, 1));
      rows.push_back(row(OP_ADC,    16'hABFF, 16'h12FF, 3'd0, 4'h1, 1, 16'h00FF, 4'h3, 1));
      rows.push_back(row(OP_SUB,    16'h0000, 16'h0001, 3'd0, 4'h0, 1, 16'h00FF, 4'h7, 1));
      rows.push_back(row(OP_SBC,    16'h0010, 16'h000F, 3'd0, 4'h1, 1, 16'h0000, 4'hE, 1));
      rows.push_back(row(OP_AND,    16'h00F0, 16'h000F, 3'd0, 4'h5, 1, 16'h0000, 4'hA, 1));
      rows.push_back(row(OP_XOR,    16'h005A, 16'h005A, 3'd0, 4'hF, 1, 16'h0000, 4'h8, 1));
      rows.push_back(row(OP_OR,     16'h0080, 16'h0001, 3'd0, 4'hF, 1, 16'h0081, 4'h0, 1));
      rows.push_back(row(OP_CP,     16'h0042, 16'h0042, 3'd0, 4'h0, 1, 16'h0000, 4'hC, 0));
      rows.push_back(row(OP_INC,    16'h00FF, 16'h0000, 3'd0, 4'h1, 1, 16'h0000, 4'hB, 1));
      rows.push_back(row(OP_DEC,    16'h0000, 16'h0000, 3'd0, 4'h0, 1, 16'h00FF, 4'h6, 1));
      rows.push_back(row(OP_DAA,    16'h009A, 16'h0000, 3'd0, 4'h0, 1, 16'h0000, 4'h9, 1));
      rows.push_back(row(OP_DAA,    16'h0000, 16'h0000, 3'd0, 4'h7, 0, 16'h0000, 4'h0, 0));
      rows.push_back(row(OP_CPL,    16'h000F, 16'h0000, 3'd0, 4'h0, 1, 16'h00F0, 4'h6, 1));
      rows.push_back(row(OP_SCF,    16'h1234, 16'h0000, 3'd0, 4'hE, 1, 16'h0034, 4'h9, 1));
      rows.push_back(row(OP_CCF,    16'h00FF, 16'h0000, 3'd0, 4'hF, 1, 16'h00FF, 4'h8, 1));
      rows.push_back(row(OP_RLC,    16'h0080, 16'h0000, 3'd0, 4'h0, 0, 16'h0000, 4'h0, 0));
      rows.push_back(row(OP_SWAP,   16'h00F0, 16'h0000, 3'd0, 4'hF, 0, 16'h0000, 4'h0, 0));
      rows.push_back(row(OP_RLA,    16'h0000, 16'h0000, 3'd0, 4'h8, 1, 16'h0000, 4'h0, 1));
      rows.push_back(row(OP_BIT,    16'h007F, 16'h0000, 3'd7, 4'h1, 1, 16'h007F, 4'hB, 0));
      rows.push_back(row(OP_RES,    16'h00FF, 16'h0000, 3'd0, 4'h0, 0, 16'h0000, 4'h0, 0));
      rows.push_back(row(OP_SET,    16'h0000, 16'h0000, 3'd7, 4'hF, 0, 16'h0000, 4'h0, 0));
      rows.push_back(row(OP_ADD16,  16'hFFFF, 16'h0001, 3'd0, 4'hC, 1, 16'h0000, 4'hB, 1));
      rows.push_back(row(OP_ADD_SP, 16'h00FF, 16'h0001, 3'd0, 4'hF, 1, 16'h0100, 4'h3, 1));
      rows.push_back(row(OP_ADD_SP, 16'h0000, 16'hABFF, 3'd0, 4'hF, 1, 16'hFFFF, 4'h0, 1));
      rows.push_back(row(OP_UNUSED, 16'hBEEF, 16'h1234, 3'd5, 4'h5, 1, 16'hBEEF, 4'h5, 0));

      foreach (rows[i]) begin
         offer(rows[i].stim, rows[i].known ? rows[i].want : alu_predict(rows[i].stim));
      end
      run_random(96);

      phase = PH_SEND_GAPS;
      send_gap_pct = 56;
      rsp_stall_pct = 0;
      run_random(110);

      phase = PH_RECV_STALLS;
      send_gap_pct = 0;
      rsp_stall_pct = 56;
      run_random(110);

      phase = PH_BOTH;
      send_gap_pct = 14;
      rsp_stall_pct = 14;
      run_random(110);

      // The result side holds off while requests keep coming.
      phase = PH_PRESSURE;
      send_gap_pct = 0;
      rsp_stall_pct = 20;
      run_random(100);

      // Drain the outstanding results, then allow for the pipeline latency.
      req_valid <= 1'b0;
      while (pending_alu_results.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      ops_hit = 0;
      foreach (op_seen[i]) if (op_seen[i]) ops_hit++;
      $display("Run covered %0d requests and %0d results, %0d of 32 operation codes,",
               sent_count, rcvd_count, ops_hit);
      $display("five flow-control phases including a %0d-cycle result hold-off; %0d errors.",
               HOLD_CYCLES, error_count);
      if (error_count == 0) begin
         $display("** eight_bit_cpu_alu_with_flags_top: PASSED **");
      end else begin
         $display("** eight_bit_cpu_alu_with_flags_top: FAILED **");
      end
      $finish;
   end

endmodule
